### hdl/go_to_goal_pose_controller_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the go-to-goal pose controller
// Concurrent checks that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef GO_TO_GOAL_POSE_CONTROLLER_TOP_MACROS_SVH
`define GO_TO_GOAL_POSE_CONTROLLER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define GGPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define GGPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GGPC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GGPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/ggpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggpc_pkg
// Types, widths and constants of the go-to-goal pose controller.
// ----------------------------------------------------------------------------
package ggpc_pkg;
    localparam int W_XY = 28;
    localparam int W_Z  = 28;
    localparam int W_DIST = 18;
    localparam logic signed [W_Z-1:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic [19:0] GAIN_COMP_Q20 = 20'd636751;

    typedef enum logic [2:0] {
        REG_GOAL_X      = 3'd0,
        REG_GOAL_Y      = 3'd1,
        REG_GAIN        = 3'd2,
        REG_SPEED_LIMIT = 3'd3,
        REG_DIST_TOL    = 3'd4,
        REG_HEAD_TOL    = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic                   valid;
        logic signed [W_XY-1:0] x;
        logic signed [W_XY-1:0] y;
        logic signed [W_Z-1:0]  z;
        logic signed [12:0]     heading;
    } t_cell_data;

    typedef struct packed {
        logic [12:0] gain;
        logic [14:0] speed_limit;
        logic [14:0] dist_tol;
        logic [12:0] head_tol;
    } t_post_cfg;

    function automatic logic signed [W_Z-1:0] atan_q24(input int idx);
        logic signed [W_Z-1:0] v;
        case (idx)
            0:  v = 28'sd13176795;
            1:  v = 28'sd7778716;
            2:  v = 28'sd4110060;
            3:  v = 28'sd2086331;
            4:  v = 28'sd1047214;
            5:  v = 28'sd524117;
            6:  v = 28'sd262123;
            7:  v = 28'sd131069;
            8:  v = 28'sd65536;
            9:  v = 28'sd32768;
            10: v = 28'sd16384;
            11: v = 28'sd8192;
            12: v = 28'sd4096;
            13: v = 28'sd2048;
            14: v = 28'sd1024;
            15: v = 28'sd512;
            16: v = 28'sd256;
            17: v = 28'sd128;
            18: v = 28'sd64;
            default: v = 28'sd32;
        endcase
        return v;
    endfunction
endpackage

### hdl/ggpc_pose_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggpc_pose_if
// Pose item channel: valid, ready and position plus heading.
// ----------------------------------------------------------------------------
interface ggpc_pose_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [12:0] heading;
    modport source (output valid, output pos_x, output pos_y, output heading, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input heading, output ready);
endinterface

### hdl/ggpc_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggpc_cmd_if
// Drive command channel: valid, ready and the two speeds.
// ----------------------------------------------------------------------------
interface ggpc_cmd_if;
    logic        valid;
    logic        ready;
    logic [14:0] linear_speed;
    logic [12:0] angular_speed;
    modport source (output valid, output linear_speed, output angular_speed, input ready);
    modport sink   (input valid, input linear_speed, input angular_speed, output ready);
endinterface

### hdl/ggpc_prerot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggpc_prerot
// Goal offset, guard scaling and quarter turn into the right half plane.
// ----------------------------------------------------------------------------
module ggpc_prerot (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [15:0]      i_pos_x,
    input  logic signed [15:0]      i_pos_y,
    input  logic signed [12:0]      i_heading,
    input  logic [13:0]             i_goal_x,
    input  logic [13:0]             i_goal_y,
    output ggpc_pkg::t_cell_data    o_data
);
    import ggpc_pkg::*;

    logic signed [16:0]     dx, dy;
    logic signed [W_XY-1:0] sx, sy;
    t_cell_data             n_data, r_data;

    assign dx = $signed({3'b000, i_goal_x}) - 17'(i_pos_x);
    assign dy = $signed({3'b000, i_goal_y}) - 17'(i_pos_y);
    assign sx = W_XY'(dx) <<< 8;
    assign sy = W_XY'(dy) <<< 8;

    always_comb begin
        n_data.valid   = i_valid;
        n_data.heading = i_heading;
        n_data.x = sx;
        n_data.y = sy;
        n_data.z = '0;
        if (sx < 0) begin
            if (sy >= 0) begin
                n_data.x = sy;
                n_data.y = -sx;
                n_data.z = HALF_PI_Q24;
            end else begin
                n_data.x = -sy;
                n_data.y = sx;
                n_data.z = -HALF_PI_Q24;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data.valid <= 1'b0;
        end else if (i_en) begin
            r_data.valid <= n_data.valid;
        end
        if (i_en) begin
            r_data.x       <= n_data.x;
            r_data.y       <= n_data.y;
            r_data.z       <= n_data.z;
            r_data.heading <= n_data.heading;
        end
    end

    assign o_data = r_data;
endmodule

### hdl/ggpc_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggpc_cordic_cell
// One vectoring micro-rotation, registered.
// ----------------------------------------------------------------------------
module ggpc_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  ggpc_pkg::t_cell_data i_data,
    output ggpc_pkg::t_cell_data o_data
);
    import ggpc_pkg::*;

    localparam logic signed [W_Z-1:0] ANGLE = atan_q24(STAGE);

    logic signed [W_XY-1:0] xs, ys;
    t_cell_data             n_data, r_data;

    assign xs = i_data.x >>> STAGE;
    assign ys = i_data.y >>> STAGE;

    always_comb begin
        n_data = i_data;
        if (i_data.y >= 0) begin
            n_data.x = i_data.x + ys;
            n_data.y = i_data.y - xs;
            n_data.z = i_data.z + ANGLE;
        end else begin
            n_data.x = i_data.x - ys;
            n_data.y = i_data.y + xs;
            n_data.z = i_data.z - ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data.valid <= 1'b0;
        end else if (i_en) begin
            r_data.valid <= n_data.valid;
        end
        if (i_en) begin
            r_data.x       <= n_data.x;
            r_data.y       <= n_data.y;
            r_data.z       <= n_data.z;
            r_data.heading <= n_data.heading;
        end
    end

    assign o_data = r_data;
endmodule

### hdl/ggpc_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ggpc_post
// Gain removal, bearing rounding, decision and speed saturation.
// ----------------------------------------------------------------------------
module ggpc_post (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  ggpc_pkg::t_cell_data i_data,
    input  ggpc_pkg::t_post_cfg  i_cfg,
    output logic                 o_valid,
    output logic [14:0]          o_linear_speed,
    output logic [12:0]          o_angular_speed
);
    import ggpc_pkg::*;

    // stage A
    logic [W_XY-2:0]        xc;
    logic signed [W_Z-1:0]  zr;
    logic signed [13:0]     bear;
    logic signed [14:0]     err;
    logic [14:0]            aerr;
    logic                   r_a_valid;
    logic [W_XY+18:0]       r_a_prod;
    logic [12:0]            r_a_err;
    // stage B
    logic [W_XY+18:0]       rnd;
    logic [W_DIST-1:0]      distance;
    logic                   r_b_valid, r_b_move, r_b_turn;
    logic [W_DIST+12:0]     r_b_lprod;
    logic [12:0]            r_b_err;
    // stage C
    logic [W_DIST+2:0]      lin;
    logic [14:0]            n_lin;
    logic [12:0]            n_ang;
    logic                   r_valid;
    logic [14:0]            r_lin;
    logic [12:0]            r_ang;

    assign xc   = i_data.x[W_XY-1] ? '0 : i_data.x[W_XY-2:0];
    assign zr   = i_data.z + W_Z'(1 << 13);
    assign bear = 14'(zr >>> 14);
    assign err  = 15'(bear) - 15'(i_data.heading);
    assign aerr = err[14] ? 15'(-err) : 15'(err);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_data.valid;
        end
        if (i_en) begin
            r_a_prod <= (W_XY+19)'(xc) * (W_XY+19)'(GAIN_COMP_Q20);
            r_a_err  <= aerr[12:0];
        end
    end

    assign rnd      = r_a_prod + (W_XY+19)'(1 << 27);
    assign distance = W_DIST'(rnd >> 28);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
        if (i_en) begin
            r_b_move  <= distance > W_DIST'(i_cfg.dist_tol);
            r_b_turn  <= r_a_err > i_cfg.head_tol;
            r_b_lprod <= (W_DIST+13)'(i_cfg.gain) * (W_DIST+13)'(distance);
            r_b_err   <= r_a_err;
        end
    end

    assign lin = (W_DIST+3)'(r_b_lprod >> 10);

    always_comb begin
        n_lin = '0;
        n_ang = '0;
        if (r_b_move) begin
            if (r_b_turn) begin
                n_ang = r_b_err;
            end else if (lin > (W_DIST+3)'(i_cfg.speed_limit)) begin
                n_lin = i_cfg.speed_limit;
            end else begin
                n_lin = lin[14:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= r_b_valid;
        end
        if (i_en) begin
            r_lin <= n_lin;
            r_ang <= n_ang;
        end
    end

    assign o_valid         = r_valid;
    assign o_linear_speed  = r_lin;
    assign o_angular_speed = r_ang;
endmodule

### hdl/go_to_goal_pose_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_to_goal_pose_controller_top
// Proportional go-to-goal controller on a pipelined vectoring CORDIC.
// ----------------------------------------------------------------------------
// One pose item in, one drive command item out. The block accepts a pose every
// cycle unless a finished command waits unaccepted; each item passes one
// pre-rotation stage, one cell per CORDIC iteration and three stages for gain
// removal, decision and saturation. The whole pipeline advances together
// and freezes only while a finished command waits at the output unaccepted.
// Configuration writes take effect at once; write them only while idle.
`include "go_to_goal_pose_controller_top_macros.svh"
module go_to_goal_pose_controller_top #(
    parameter int CORDIC_STAGES = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data,
    ggpc_pose_if.sink   s_pose,
    ggpc_cmd_if.source  m_cmd
);
    import ggpc_pkg::*;

    logic [13:0] r_goal_x, r_goal_y;
    logic [12:0] r_gain, r_head_tol;
    logic [14:0] r_speed_limit, r_dist_tol;

    logic        advance;
    t_cell_data  chain [0:CORDIC_STAGES];
    t_post_cfg   post_cfg;

    // Register file: mask to width, ignore unknown indexes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x      <= 14'd1024;
            r_goal_y      <= 14'd1024;
            r_gain        <= 13'd1024;
            r_speed_limit <= 15'd1024;
            r_dist_tol    <= 15'd102;
            r_head_tol    <= 13'd205;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_GOAL_X:      r_goal_x      <= i_cfg_data[13:0];
                REG_GOAL_Y:      r_goal_y      <= i_cfg_data[13:0];
                REG_GAIN:        r_gain        <= i_cfg_data[12:0];
                REG_SPEED_LIMIT: r_speed_limit <= i_cfg_data;
                REG_DIST_TOL:    r_dist_tol    <= i_cfg_data;
                REG_HEAD_TOL:    r_head_tol    <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // Advance everything unless the output holds an item nobody took.
    assign advance      = !m_cmd.valid || m_cmd.ready;
    assign s_pose.ready = advance;

    ggpc_prerot u_prerot (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (advance),
        .i_valid   (s_pose.valid),
        .i_pos_x   (s_pose.pos_x),
        .i_pos_y   (s_pose.pos_y),
        .i_heading (s_pose.heading),
        .i_goal_x  (r_goal_x),
        .i_goal_y  (r_goal_y),
        .o_data    (chain[0])
    );

    // Row of micro-rotation cells, one per iteration.
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        ggpc_cordic_cell #(.STAGE(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (advance),
            .i_data  (chain[g]),
            .o_data  (chain[g+1])
        );
    end

    assign post_cfg.gain        = r_gain;
    assign post_cfg.speed_limit = r_speed_limit;
    assign post_cfg.dist_tol    = r_dist_tol;
    assign post_cfg.head_tol    = r_head_tol;

    ggpc_post u_post (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (advance),
        .i_data          (chain[CORDIC_STAGES]),
        .i_cfg           (post_cfg),
        .o_valid         (m_cmd.valid),
        .o_linear_speed  (m_cmd.linear_speed),
        .o_angular_speed (m_cmd.angular_speed)
    );

    // Never drive and turn at once.
    `GGPC_ASSERT_IMP(a_one_motion, i_clk, i_rst_n, m_cmd.valid, m_cmd.linear_speed == 15'd0 || m_cmd.angular_speed == 13'd0)
    // Linear speed stays within the limit.
    `GGPC_ASSERT_IMP(a_lin_limit, i_clk, i_rst_n, m_cmd.valid, m_cmd.linear_speed <= r_speed_limit)
    // Turning happens only above the heading tolerance.
    `GGPC_ASSERT_IMP(a_turn_tol, i_clk, i_rst_n, m_cmd.valid && m_cmd.angular_speed != 13'd0, m_cmd.angular_speed > r_head_tol)
endmodule

### tb/go_to_goal_pose_controller_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_to_goal_pose_controller_checker
// Watches the pose and command channels, predicts each drive command from
// the accepted pose and the current registers, and compares in order.
// ----------------------------------------------------------------------------
module go_to_goal_pose_controller_checker #(
    parameter int CORDIC_STAGES = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data,
    ggpc_pose_if        pose,
    ggpc_cmd_if         cmd,
    output int          o_errors,
    output int          o_pending
);
    import ggpc_pkg::*;

    typedef struct packed {
        logic [14:0] lin;
        logic [12:0] ang;
    } t_cmd;

    logic [13:0] goal_x, goal_y;
    logic [12:0] gain, head_tol;
    logic [14:0] spd_lim, dist_tol;
    t_cmd        cmd_q[$];

    function automatic longint angle_q24(int i);
        longint tbl[20] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
            262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
            256, 128, 64, 32};
        return tbl[i];
    endfunction

    function automatic t_cmd drive_command(logic signed [15:0] px,
                                           logic signed [15:0] py,
                                           logic signed [12:0] hd);
        longint dx, dy, x, y, z, xs, ys, distance, brg, err, lin;
        int     n;
        t_cmd   c;
        dx = (longint'(goal_x) - px) * 256;
        dy = (longint'(goal_y) - py) * 256;
        x = dx; y = dy; z = 0;
        n = (CORDIC_STAGES > 20) ? 20 : CORDIC_STAGES;
        // pre-rotate left half plane vectors by a quarter turn
        if (dx < 0) begin
            if (dy >= 0) begin
                x = dy; y = -dx; z = 26353589;
            end else begin
                x = -dy; y = dx; z = -26353589;
            end
        end
        for (int i = 0; i < n; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += angle_q24(i);
            end else begin
                x -= ys; y += xs; z -= angle_q24(i);
            end
        end
        if (x < 0) x = 0;
        distance = (x * 636751 + (longint'(1) << 27)) >>> 28;
        brg = (z + 8192) >>> 14;
        err = brg - hd;
        if (err < 0) err = -err;
        c = '0;
        if (distance > dist_tol) begin
            if (err > head_tol) begin
                c.ang = err[12:0];
            end else begin
                lin = (longint'(gain) * distance) >>> 10;
                if (lin > spd_lim) lin = spd_lim;
                c.lin = lin[14:0];
            end
        end
        return c;
    endfunction

    assign o_pending = cmd_q.size();

    always @(posedge i_clk) begin
        t_cmd want;
        if (!i_rst_n) begin
            goal_x <= 14'd1024; goal_y <= 14'd1024; gain <= 13'd1024;
            spd_lim <= 15'd1024; dist_tol <= 15'd102; head_tol <= 13'd205;
            o_errors <= 0;
            cmd_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_GOAL_X:      goal_x <= i_cfg_data[13:0];
                    REG_GOAL_Y:      goal_y <= i_cfg_data[13:0];
                    REG_GAIN:        gain <= i_cfg_data[12:0];
                    REG_SPEED_LIMIT: spd_lim <= i_cfg_data;
                    REG_DIST_TOL:    dist_tol <= i_cfg_data;
                    REG_HEAD_TOL:    head_tol <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (pose.valid && pose.ready)
                cmd_q.push_back(drive_command(pose.pos_x, pose.pos_y, pose.heading));
            if (cmd.valid && cmd.ready) begin
                if (cmd_q.size() == 0) begin
                    $display("%0t: unexpected command lin=%0d ang=%0d", $time,
                             cmd.linear_speed, cmd.angular_speed);
                    o_errors <= o_errors + 1;
                end else begin
                    want = cmd_q.pop_front();
                    if (want.lin !== cmd.linear_speed || want.ang !== cmd.angular_speed) begin
                        $display("%0t: command mismatch expected lin=%0d ang=%0d actual lin=%0d ang=%0d",
                                 $time, want.lin, want.ang, cmd.linear_speed,
                                 cmd.angular_speed);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

### tb/go_to_goal_pose_controller_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_to_goal_pose_controller_top_tb
// Drives poses through the controller under several register settings with
// bursty input and a stalling output; the checker predicts every command.
// ----------------------------------------------------------------------------
module go_to_goal_pose_controller_top_tb;
    import ggpc_pkg::*;

    localparam int STAGES   = 14;
    localparam int LATENCY  = STAGES + 4;
    localparam int WDOG_MAX = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [14:0] i_cfg_data = '0;
    int          errors, pending;
    int          idle_cycles = 0;
    logic        stall_mode = 1'b0;

    ggpc_pose_if pose_ch ();
    ggpc_cmd_if  cmd_ch ();

    always #6 i_clk = ~i_clk;

    go_to_goal_pose_controller_top #(.CORDIC_STAGES(STAGES)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_pose(pose_ch.sink), .m_cmd(cmd_ch.source)
    );

    go_to_goal_pose_controller_checker #(.CORDIC_STAGES(STAGES)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .pose(pose_ch), .cmd(cmd_ch), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        pose_ch.valid = 1'b0;
        pose_ch.pos_x = '0;
        pose_ch.pos_y = '0;
        pose_ch.heading = '0;
        cmd_ch.ready = 1'b0;
    end

    // Receiver: alternate between a free-flowing and a stalling pattern.
    always @(posedge i_clk) begin
        if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
        cmd_ch.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((pose_ch.valid && pose_ch.ready) || (cmd_ch.valid && cmd_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("go_to_goal_pose_controller_top_tb: errors");
            $finish;
        end
    end

    // Write one register, then idle the port.
    task automatic write_reg(t_reg_idx idx, logic [14:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Hold one pose item until it is accepted; drop valid afterwards
    // only if no next item follows.
    task automatic send_pose(logic [15:0] px, logic [15:0] py, logic [12:0] hd,
                             bit keep);
        pose_ch.valid <= 1'b1;
        pose_ch.pos_x <= px;
        pose_ch.pos_y <= py;
        pose_ch.heading <= hd;
        do @(posedge i_clk); while (!pose_ch.ready);
        if (!keep) begin
            pose_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Wait until every command has come back, then let the pipe drain.
    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Random poses in bursts from four mixes, one of them near the reset goal, so every branch fires.
    task automatic random_burst(int count);
        int sent, blen;
        logic [15:0] px, py;
        logic [12:0] hd;
        sent = 0;
        while (sent < count) begin
            blen = $urandom_range(1, 20);
            for (int k = 0; k < blen && sent < count; k++) begin
                case ($urandom_range(0, 3))
                    0: begin
                        px = 16'($urandom); py = 16'($urandom);
                    end
                    1: begin
                        px = 16'($urandom_range(0, 12288));
                        py = 16'($urandom_range(0, 12288));
                    end
                    2: begin
                        px = 16'(1024 + $urandom_range(0, 400) - 200);
                        py = 16'(1024 + $urandom_range(0, 400) - 200);
                    end
                    default: begin
                        px = 16'($urandom_range(0, 4096) - 2048); py = 16'($urandom);
                    end
                endcase
                hd = ($urandom_range(0, 7) == 0) ? 13'($urandom)
                                                 : 13'($urandom_range(0, 6434) - 3217);
                sent++;
                send_pose(px, py, hd, (k < blen - 1) && (sent < count));
            end
            repeat ($urandom_range(0, 6)) @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset registers, field extremes, stop, turn and drive.
        send_pose(16'd1024, 16'd1024, 13'd0, 0);         // zero vector stops
        send_pose(16'd1000, 16'd1010, 13'd0, 0);         // goal reached
        send_pose(16'h8000, 16'h8000, 13'd804, 0);       // far, drive or turn
        send_pose(16'h7FFF, 16'h7FFF, -13'sd3217, 0);
        send_pose(16'h7FFF, 16'h8000, 13'd3217, 0);
        send_pose(16'h8000, 16'h7FFF, 13'h0FFF, 0);      // heading out of range
        send_pose(16'd0, 16'd1024, 13'h1000, 0);
        send_pose(16'd2048, 16'd1024, 13'd3217, 0);      // bearing pi
        send_pose(16'd2048, 16'd2048, -13'sd2413, 0);
        send_pose(16'd0, 16'd0, 13'd804, 1);             // drive at 45 degrees
        send_pose(16'd1024, 16'd0, 13'd1608, 1);
        send_pose(16'd1024, 16'd2048, -13'sd1608, 0);
        drain();

        // Extremes of every register.
        write_reg(REG_GOAL_X, 15'h3FFF);
        write_reg(REG_GOAL_Y, 15'd0);
        write_reg(REG_GAIN, 15'h1FFF);
        write_reg(REG_SPEED_LIMIT, 15'h7FFF);
        write_reg(REG_DIST_TOL, 15'd0);
        write_reg(REG_HEAD_TOL, 15'h1FFF);
        write_reg(t_reg_idx'(3'd7), 15'h7FFF);           // unknown index ignored
        send_pose(16'h8000, 16'h7FFF, 13'd0, 0);
        send_pose(16'h3FFF, 16'd0, 13'd0, 0);
        send_pose(16'd0, 16'd0, 13'h1000, 0);
        random_burst(150);
        drain();

        write_reg(REG_GOAL_X, 15'd0);
        write_reg(REG_GOAL_Y, 15'h3FFF);
        write_reg(REG_GAIN, 15'd0);
        write_reg(REG_SPEED_LIMIT, 15'd0);
        write_reg(REG_DIST_TOL, 15'h7FFF);
        write_reg(REG_HEAD_TOL, 15'd0);
        random_burst(100);
        drain();

        write_reg(REG_GOAL_X, 15'd6144);
        write_reg(REG_GOAL_Y, 15'd12288);
        write_reg(REG_GAIN, 15'd3000);
        write_reg(REG_SPEED_LIMIT, 15'd4000);
        write_reg(REG_DIST_TOL, 15'd500);
        write_reg(REG_HEAD_TOL, 15'd6434);
        random_burst(200);
        drain();

        // Random settings for the rest.
        for (int p = 0; p < 5; p++) begin
            write_reg(REG_GOAL_X, 15'($urandom_range(0, 12288)));
            write_reg(REG_GOAL_Y, 15'($urandom_range(0, 12288)));
            write_reg(REG_GAIN, 15'($urandom_range(0, 8191)));
            write_reg(REG_SPEED_LIMIT, 15'($urandom_range(0, 32767)));
            write_reg(REG_DIST_TOL, 15'($urandom_range(0, 3000)));
            write_reg(REG_HEAD_TOL, 15'($urandom_range(0, 1500)));
            random_burst(100);
            drain();
        end

        if (errors == 0) begin
            $display("go_to_goal_pose_controller_top_tb: clean");
        end else begin
            $display("go_to_goal_pose_controller_top_tb: errors");
        end
        $finish;
    end
endmodule
